[hw/rtl/zbpm_pkg.sv]
`timescale 1ns / 1ps

package zbpm_pkg;

   localparam int IMG_WIDTH  = 640;
   localparam int IMG_HEIGHT = 480;
   localparam int PIXELS     = IMG_WIDTH * IMG_HEIGHT;
   localparam int ADDR_W     = $clog2(PIXELS);
   localparam int COL_W      = $clog2(IMG_WIDTH);
   localparam int ROW_W      = $clog2(IMG_HEIGHT);

   // |coord| (16 bits, up to 32768) times focal (12 bits) fits in 28 bits
   localparam int PROD_W = 28;
   localparam int DIVC_W = $clog2(PROD_W + 1);
   // center plus or minus quotient, with sign
   localparam int POS_W  = PROD_W + 3;
   localparam int MEM_W  = 20;

   localparam logic [1:0] CMD_SPLAT = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic [1:0] CSR_FOCAL_X  = 2'd0;
   localparam logic [1:0] CSR_FOCAL_Y  = 2'd1;
   localparam logic [1:0] CSR_CENTER_X = 2'd2;
   localparam logic [1:0] CSR_CENTER_Y = 2'd3;

   localparam logic [11:0] FOCAL_RESET    = 12'd525;
   localparam logic [9:0]  CENTER_X_RESET = 10'd320;
   localparam logic [8:0]  CENTER_Y_RESET = 9'd240;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic [15:0]        point_z;
      logic [3:0]         object_label;
      logic [9:0]         pixel_col;
      logic [8:0]         pixel_row;
   } req_type;

   typedef struct packed {
      logic        in_view;
      logic        written;
      logic [9:0]  hit_col;
      logic [8:0]  hit_row;
      logic [3:0]  mask_value;
      logic [15:0] depth_value;
   } rsp_type;

   typedef struct packed {
      logic item_load;
      logic res_zero;
      logic div_start;
      logic div_sel_y;
      logic cap_x;
      logic cap_y;
      logic pix_calc;
      logic mem_rd;
      logic upd;
      logic clr_step;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       z_zero;
      logic       div_busy;
      logic       clr_last;
   } ctrl_stat_type;

endpackage

[hw/rtl/zbuffer_point_mask_projector_top.sv]
`timescale 1ns / 1ps

// channel   signals                          word
// req       req_valid / req_ready            zbpm_pkg::req_type: command and point
// rsp       rsp_valid / rsp_ready            zbpm_pkg::rsp_type: one result per command
// csr       csr_we, csr_index, csr_wdata     focal_x, focal_y, center_x, center_y
//
// Sequence: a splat goes through dispatch, the shared bit-serial divider for x
// and then y (28 quotient bits each, with a handoff between them), bounds, store
// read, update and result load. A read takes the same path but skips the divider.
// A zero-depth splat or the unused command goes straight from dispatch to result load.
// A clear sweeps the store one pixel a cycle over all IMG_WIDTH*IMG_HEIGHT (307200) pixels.
// Reset: synchronous; afterwards the same sweep zeroes the store
// before req_ready rises. Configuration writes are taken during the sweep.
// Stalls: the result sits in an output register, so a new word is taken while
// rsp waits; the next result holds in the result register, with req_ready low,
// until rsp drains.
module zbuffer_point_mask_projector_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  zbpm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output zbpm_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [11:0]       csr_wdata
);

   zbpm_pkg::ctrl_cmd_type  ctl;
   zbpm_pkg::ctrl_stat_type stat;

   // sequencer: dispatch, divider handoff, store sweep, result handoff
   zbpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // projection math, depth/mask store, result registers
   zbpm_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // one word at a time: after accept the input side closes
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while an item is in flight");

   // the store has one write port
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(ctl.upd && ctl.clr_step))
      else $error("sweep and update write together");

   // never restart the divider mid-operation
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.div_start |-> !stat.div_busy)
      else $error("divider started while busy");

   // never overwrite a result still waiting on rsp
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> (!rsp_valid || rsp_ready))
      else $error("pending result overwritten");
`endif

endmodule

[hw/rtl/zbpm_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module zbpm_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [zbpm_pkg::PROD_W-1:0] dividend,
   input  logic [15:0]                 divisor,
   output logic                        busy,
   output logic [zbpm_pkg::PROD_W-1:0] quotient
);

   logic [zbpm_pkg::DIVC_W-1:0] cnt_ff, cnt_in;
   logic [zbpm_pkg::PROD_W-1:0] quo_ff, quo_in;
   logic [15:0]                 rem_ff, rem_in;
   logic [15:0]                 dvs_ff, dvs_in;
   logic [16:0]                 trial;

   always_comb begin
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      trial  = {rem_ff, quo_ff[zbpm_pkg::PROD_W-1]};
      if (start) begin
         cnt_in = zbpm_pkg::DIVC_W'(zbpm_pkg::PROD_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 16'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[zbpm_pkg::PROD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[zbpm_pkg::PROD_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

endmodule

[hw/rtl/zbpm_datapath.sv]
`timescale 1ns / 1ps

module zbpm_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  zbpm_pkg::req_type      req_data,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [11:0]            csr_wdata,
   input  zbpm_pkg::ctrl_cmd_type ctl,
   output zbpm_pkg::ctrl_stat_type stat,
   output zbpm_pkg::rsp_type      rsp_data
);

   zbpm_pkg::req_type item_ff;
   logic [11:0] fx_ff, fy_ff;
   logic [9:0]  cx_ff;
   logic [8:0]  cy_ff;

   logic [15:0] mag_x, mag_y, mag;
   logic [11:0] focal;
   logic [zbpm_pkg::PROD_W-1:0] prod, div_quo, qx_ff, qy_ff;
   logic div_busy;

   logic signed [zbpm_pkg::POS_W-1:0] colw, roww;
   logic col_ok, row_ok, rd_ok;
   logic [zbpm_pkg::COL_W-1:0] pcol_ff;
   logic [zbpm_pkg::ROW_W-1:0] prow_ff;
   logic view_ff;

   logic [zbpm_pkg::ADDR_W-1:0] rd_addr, addr_ff, clr_ff, waddr;
   logic [zbpm_pkg::MEM_W-1:0]  mem [zbpm_pkg::PIXELS];
   logic [zbpm_pkg::MEM_W-1:0]  rdata_ff, wdata;
   logic we, win, is_splat;
   logic [15:0] st_depth;

   zbpm_pkg::rsp_type res_ff, res_in, rsp_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff <= zbpm_pkg::FOCAL_RESET;
         fy_ff <= zbpm_pkg::FOCAL_RESET;
         cx_ff <= zbpm_pkg::CENTER_X_RESET;
         cy_ff <= zbpm_pkg::CENTER_Y_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            zbpm_pkg::CSR_FOCAL_X:  fx_ff <= csr_wdata;
            zbpm_pkg::CSR_FOCAL_Y:  fy_ff <= csr_wdata;
            zbpm_pkg::CSR_CENTER_X: cx_ff <= csr_wdata[9:0];
            zbpm_pkg::CSR_CENTER_Y: cy_ff <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.item_load) item_ff <= req_data;
      if (ctl.cap_x) qx_ff <= div_quo;
      if (ctl.cap_y) qy_ff <= div_quo;
   end

   // magnitude times focal, registered inside the divider
   assign mag_x = item_ff.point_x[15] ? 16'(-item_ff.point_x) : $unsigned(item_ff.point_x);
   assign mag_y = item_ff.point_y[15] ? 16'(-item_ff.point_y) : $unsigned(item_ff.point_y);
   assign mag   = ctl.div_sel_y ? mag_y : mag_x;
   assign focal = ctl.div_sel_y ? fy_ff : fx_ff;
   assign prod  = zbpm_pkg::PROD_W'({12'b0, mag} * {16'b0, focal});

   zbpm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (prod),
      .divisor  (item_ff.point_z),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // pixel position and bounds
   always_comb begin
      colw = item_ff.point_x[15] ?
             $signed(zbpm_pkg::POS_W'(cx_ff)) - $signed(zbpm_pkg::POS_W'(qx_ff)) :
             $signed(zbpm_pkg::POS_W'(cx_ff)) + $signed(zbpm_pkg::POS_W'(qx_ff));
      roww = item_ff.point_y[15] ?
             $signed(zbpm_pkg::POS_W'(cy_ff)) - $signed(zbpm_pkg::POS_W'(qy_ff)) :
             $signed(zbpm_pkg::POS_W'(cy_ff)) + $signed(zbpm_pkg::POS_W'(qy_ff));
      col_ok = !colw[zbpm_pkg::POS_W-1] &&
               (colw < $signed(zbpm_pkg::POS_W'(zbpm_pkg::IMG_WIDTH)));
      row_ok = !roww[zbpm_pkg::POS_W-1] &&
               (roww < $signed(zbpm_pkg::POS_W'(zbpm_pkg::IMG_HEIGHT)));
      rd_ok  = (32'(item_ff.pixel_col) < 32'(zbpm_pkg::IMG_WIDTH)) &&
               (32'(item_ff.pixel_row) < 32'(zbpm_pkg::IMG_HEIGHT));
   end

   assign is_splat = (item_ff.cmd == zbpm_pkg::CMD_SPLAT);

   always_ff @(posedge clock) begin
      if (ctl.pix_calc) begin
         if (is_splat) begin
            view_ff <= col_ok && row_ok;
            pcol_ff <= (col_ok && row_ok) ? zbpm_pkg::COL_W'(colw) : '0;
            prow_ff <= (col_ok && row_ok) ? zbpm_pkg::ROW_W'(roww) : '0;
         end else begin
            view_ff <= rd_ok;
            pcol_ff <= rd_ok ? zbpm_pkg::COL_W'(item_ff.pixel_col) : '0;
            prow_ff <= rd_ok ? zbpm_pkg::ROW_W'(item_ff.pixel_row) : '0;
         end
      end
   end

   assign rd_addr = zbpm_pkg::ADDR_W'(prow_ff) * zbpm_pkg::ADDR_W'(zbpm_pkg::IMG_WIDTH)
                    + zbpm_pkg::ADDR_W'(pcol_ff);

   // store word: label above depth
   assign st_depth = rdata_ff[15:0];
   assign win   = view_ff && ((st_depth == 16'd0) || (item_ff.point_z < st_depth));
   assign we    = ctl.clr_step || (ctl.upd && is_splat && win);
   assign waddr = ctl.clr_step ? clr_ff : addr_ff;
   assign wdata = ctl.clr_step ? '0 : {item_ff.object_label, item_ff.point_z};

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (ctl.mem_rd) begin
         rdata_ff <= mem[rd_addr];
         addr_ff  <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctl.clr_step) begin
         clr_ff <= stat.clr_last ? '0 : clr_ff + 1'b1;
      end
   end

   always_comb begin
      res_in = res_ff;
      if (ctl.res_zero) begin
         res_in = '0;
      end else if (ctl.upd) begin
         res_in = '0;
         if (is_splat) begin
            res_in.in_view = view_ff;
            res_in.written = win;
            res_in.hit_col = 10'(pcol_ff);
            res_in.hit_row = 9'(prow_ff);
         end else if (view_ff) begin
            res_in.mask_value  = rdata_ff[19:16];
            res_in.depth_value = rdata_ff[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (ctl.rsp_load) rsp_ff <= res_ff;
   end

   assign rsp_data      = rsp_ff;
   assign stat.cmd      = item_ff.cmd;
   assign stat.z_zero   = (item_ff.point_z == 16'd0);
   assign stat.div_busy = div_busy;
   assign stat.clr_last = (clr_ff == zbpm_pkg::ADDR_W'(zbpm_pkg::PIXELS - 1));

endmodule

[hw/rtl/zbpm_ctrl.sv]
`timescale 1ns / 1ps

module zbpm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  zbpm_pkg::ctrl_stat_type stat,
   output zbpm_pkg::ctrl_cmd_type  ctl
);

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DISP = 4'd2;
   localparam logic [3:0] S_DIVX = 4'd3;
   localparam logic [3:0] S_DIVY = 4'd4;
   localparam logic [3:0] S_PIX  = 4'd5;
   localparam logic [3:0] S_RD   = 4'd6;
   localparam logic [3:0] S_UPD  = 4'd7;
   localparam logic [3:0] S_CLR  = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         S_INIT: begin
            ctl.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               ctl.item_load = 1'b1;
               state_in      = S_DISP;
            end
         end
         S_DISP: begin
            ctl.res_zero = 1'b1;
            case (stat.cmd)
               zbpm_pkg::CMD_SPLAT: begin
                  if (stat.z_zero) begin
                     state_in = S_DONE;
                  end else begin
                     ctl.div_start = 1'b1;
                     state_in      = S_DIVX;
                  end
               end
               zbpm_pkg::CMD_READ:  state_in = S_PIX;
               zbpm_pkg::CMD_CLEAR: state_in = S_CLR;
               default:             state_in = S_DONE;
            endcase
         end
         S_DIVX: begin
            if (!stat.div_busy) begin
               ctl.cap_x     = 1'b1;
               ctl.div_start = 1'b1;
               ctl.div_sel_y = 1'b1;
               state_in      = S_DIVY;
            end
         end
         S_DIVY: begin
            if (!stat.div_busy) begin
               ctl.cap_y = 1'b1;
               state_in  = S_PIX;
            end
         end
         S_PIX: begin
            ctl.pix_calc = 1'b1;
            state_in     = S_RD;
         end
         S_RD: begin
            ctl.mem_rd = 1'b1;
            state_in   = S_UPD;
         end
         S_UPD: begin
            ctl.upd  = 1'b1;
            state_in = S_DONE;
         end
         S_CLR: begin
            ctl.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
